### rtl/core/php_pkg.sv
// shared types, constants and helper functions of the perfect hash lookup block
// no dependencies; used by php_datapath, php_ctrl and the top level, not by php_div
package php_pkg;

  // default sizes of the tables
  localparam int MAX_CHUNKS_DEF     = 8;
  localparam int MAX_BUCKETS_DEF    = 256;
  localparam int MAX_TABLE_ROWS_DEF = 1024;
  localparam int RANGE_ENTRIES_DEF  = 4096;

  // columns of the random table and number of candidates
  localparam int TABLE_COLS  = 6;
  localparam int CHOICE_MOD  = 3;

  // command codes
  localparam logic [2:0] CMD_EVAL   = 3'd0;
  localparam logic [2:0] CMD_SPLIT  = 3'd1;
  localparam logic [2:0] CMD_PAIR   = 3'd2;
  localparam logic [2:0] CMD_OFFSET = 3'd3;
  localparam logic [2:0] CMD_WORD   = 3'd4;
  localparam logic [2:0] CMD_FACTOR = 3'd5;
  localparam logic [2:0] CMD_CHOICE = 3'd6;

  // configuration register indexes
  localparam logic [2:0] REG_CHUNK_BITS  = 3'd0;
  localparam logic [2:0] REG_CHUNK_COUNT = 3'd1;
  localparam logic [2:0] REG_BUCKETS     = 3'd2;
  localparam logic [2:0] REG_SPLIT_MASK  = 3'd3;
  localparam logic [2:0] REG_PAIR_MASK   = 3'd4;
  localparam logic [2:0] REG_TABLE_ROWS  = 3'd5;

  // configuration register reset values
  localparam logic [5:0]  CHUNK_BITS_RST  = 6'd16;
  localparam logic [3:0]  CHUNK_COUNT_RST = 4'd4;
  localparam logic [8:0]  BUCKETS_RST     = 9'd256;
  localparam logic [6:0]  SPLIT_MASK_RST  = 7'd32;
  localparam logic [6:0]  PAIR_MASK_RST   = 7'd32;
  localparam logic [10:0] TABLE_ROWS_RST  = 11'd1024;

  typedef struct packed {
    logic [5:0]  chunk_bits;
    logic [3:0]  chunk_count;
    logic [8:0]  bucket_count;
    logic [6:0]  split_mask_bits;
    logic [6:0]  pair_mask_bits;
    logic [10:0] table_rows;
  } cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       wr;
    logic [1:0] hsel;
    logic       ci_load;
    logic       ci_dec;
    logic       coef_rd;
    logic       r_init;
    logic       mul_en;
    logic       mul_src;
    logic [1:0] mul_step;
    logic       acc;
    logic       div_start;
    logic       div_src;
    logic       hres_store;
    logic       off_rd;
    logic       off_sel;
    logic       base_cap;
    logic       top_cap;
    logic       fac_rd;
    logic       rw_rd;
    logic       rw_sel;
    logic       a_cap;
    logic       x_cap;
    logic [1:0] jsel;
    logic       f_store;
    logic       fix;
    logic       ch_rd;
    logic [1:0] ch_sel;
    logic       ch_acc;
    logic       ch_clr;
    logic       out_fire;
    logic       out_empty;
  } ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic ci_zero;
    logic div_done;
    logic empty;
  } stat_t;

  // mask of the low bits, all ones from 64 bits up
  function automatic logic [63:0] low_mask(input logic [6:0] bits);
    logic [63:0] m;
    if (bits >= 7'd64) begin
      m = '1;
    end else begin
      m = (64'd1 << bits) - 64'd1;
    end
    return m;
  endfunction

  // remainder modulo three of a small sum
  function automatic logic [1:0] mod3(input logic [3:0] s);
    logic [1:0] r;
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9:   r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:  r = 2'd1;
      4'd2, 4'd5, 4'd8, 4'd11:  r = 2'd2;
      default:                  r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

### rtl/core/php_div.sv
// bit-serial 64-bit modulo unit, one remainder bit per cycle
// depends on nothing but its ports
module php_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] remainder
);

  logic        run;
  logic [5:0]  cnt;
  logic [63:0] dvd;
  logic [63:0] dsr;
  logic [64:0] trial;
  logic [64:0] diff;

  // shift in the next dividend bit and try a subtraction
  assign trial = {remainder, dvd[63]};
  assign diff  = trial - {1'b0, dsr};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and dividend shifter
  always_ff @(posedge clk) begin
    if (start) begin
      remainder <= '0;
      dvd       <= dividend;
      dsr       <= divisor;
    end else if (run) begin
      dvd <= {dvd[62:0], 1'b0};
      if (!diff[64]) begin
        remainder <= diff[63:0];
      end else begin
        remainder <= trial[63:0];
      end
    end
  end

endmodule

### rtl/core/php_datapath.sv
// datapath of the perfect hash lookup: tables, multiplier, modulo unit, result
// depends on php_pkg and php_div
module php_datapath #(
  parameter int MAX_CHUNKS     = php_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_BUCKETS    = php_pkg::MAX_BUCKETS_DEF,
  parameter int MAX_TABLE_ROWS = php_pkg::MAX_TABLE_ROWS_DEF,
  parameter int RANGE_ENTRIES  = php_pkg::RANGE_ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  php_pkg::cfg_t  cfg,
  input  logic [2:0]     command,
  input  logic [63:0]    key,
  input  logic [12:0]    table_index,
  input  logic [63:0]    table_value,
  input  php_pkg::ctrl_t ctl,
  output php_pkg::stat_t st,
  output logic           valid,
  output logic [11:0]    hash_value,
  output logic           empty_bucket
);

  localparam int STRIDE      = MAX_CHUNKS + 1;
  localparam int PAIR_DEPTH  = MAX_BUCKETS * 2 * STRIDE;
  localparam int OFF_DEPTH   = MAX_BUCKETS + 1;
  localparam int RW_DEPTH    = php_pkg::TABLE_COLS * MAX_TABLE_ROWS;
  localparam int SAW         = $clog2(STRIDE);
  localparam int PAW         = $clog2(PAIR_DEPTH);
  localparam int OAW         = $clog2(OFF_DEPTH);
  localparam int RWAW        = $clog2(RW_DEPTH);
  localparam int FAW         = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CAW         = $clog2(RANGE_ENTRIES);
  localparam int NW          = $clog2(STRIDE);
  localparam int BW          = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int RWW         = (MAX_TABLE_ROWS > 1) ? $clog2(MAX_TABLE_ROWS) : 1;

  // latched item
  logic [2:0]  cmd_r;
  logic [63:0] key_r;
  logic [12:0] idx_r;
  logic [63:0] val_r;

  // memories and their read data
  logic [63:0] split_mem [STRIDE];
  logic [63:0] pair_mem  [PAIR_DEPTH];
  logic [12:0] off_mem   [OFF_DEPTH];
  logic [63:0] rw_mem    [RW_DEPTH];
  logic [63:0] fac_mem   [MAX_BUCKETS];
  logic [1:0]  ch_mem    [RANGE_ENTRIES];
  logic [63:0] split_q, pair_q, rw_q, fac_q;
  logic [12:0] off_q;
  logic [1:0]  ch_q;
  logic        ch_ok;

  // working registers
  logic [NW-1:0]  ci;
  logic [63:0]    r, kw, prod, a_reg, x_reg;
  logic [BW-1:0]  b;
  logic [RWW-1:0] row0, row1;
  logic [12:0]    base, range;
  logic [13:0]    f [3];
  logic [3:0]     sum;

  // clamped configuration
  logic [31:0]   n_full, m_full, rows_full;
  logic [NW-1:0] n;
  logic [63:0]   kmask, smask, pmask, hmask;
  logic [5:0]    k;

  assign k     = cfg.chunk_bits;
  assign kmask = php_pkg::low_mask({1'b0, cfg.chunk_bits});
  assign smask = php_pkg::low_mask(cfg.split_mask_bits);
  assign pmask = php_pkg::low_mask(cfg.pair_mask_bits);
  assign hmask = (ctl.hsel == 2'd0) ? smask : pmask;

  always_comb begin
    n_full = (32'(cfg.chunk_count) > 32'(MAX_CHUNKS)) ? 32'(MAX_CHUNKS)
                                                     : 32'(cfg.chunk_count);
    if (cfg.bucket_count == '0) begin
      m_full = 32'd1;
    end else if (32'(cfg.bucket_count) > 32'(MAX_BUCKETS)) begin
      m_full = 32'(MAX_BUCKETS);
    end else begin
      m_full = 32'(cfg.bucket_count);
    end
    if (cfg.table_rows == '0) begin
      rows_full = 32'd1;
    end else if (32'(cfg.table_rows) > 32'(MAX_TABLE_ROWS)) begin
      rows_full = 32'(MAX_TABLE_ROWS);
    end else begin
      rows_full = 32'(cfg.table_rows);
    end
  end
  assign n = NW'(n_full);

  // item latch
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      cmd_r <= command;
      key_r <= key;
      idx_r <= table_index;
      val_r <= table_value;
    end
  end

  // read addresses
  logic [31:0]     pair_addr_full, rw_addr_full;
  logic [RWW-1:0]  rw_row;
  logic [13:0]     ch_f;

  assign pair_addr_full = (32'(b) * 32'd2 + 32'(ctl.hsel) - 32'd1) * 32'(STRIDE) + 32'(ci);
  assign rw_row         = ctl.rw_sel ? row1 : row0;
  assign rw_addr_full   = 32'(rw_row) * 32'(php_pkg::TABLE_COLS) + 32'(ctl.jsel) * 32'd2
                          + 32'(ctl.rw_sel);
  assign ch_f           = f[ctl.ch_sel];

  // coefficient tables
  always_ff @(posedge clk) begin
    if (ctl.wr && cmd_r == php_pkg::CMD_SPLIT && 32'(idx_r) < 32'(STRIDE)) begin
      split_mem[SAW'(idx_r)] <= val_r;
    end
    if (ctl.coef_rd) begin
      split_q <= split_mem[SAW'(ci)];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.wr && cmd_r == php_pkg::CMD_PAIR && 32'(idx_r) < 32'(PAIR_DEPTH)) begin
      pair_mem[PAW'(idx_r)] <= val_r;
    end
    if (ctl.coef_rd) begin
      pair_q <= pair_mem[PAW'(pair_addr_full)];
    end
  end

  // range offsets
  always_ff @(posedge clk) begin
    if (ctl.wr && cmd_r == php_pkg::CMD_OFFSET && 32'(idx_r) < 32'(OFF_DEPTH)) begin
      off_mem[OAW'(idx_r)] <= val_r[12:0];
    end
    if (ctl.off_rd) begin
      off_q <= off_mem[OAW'(32'(b) + 32'(ctl.off_sel))];
    end
  end

  // random words
  always_ff @(posedge clk) begin
    if (ctl.wr && cmd_r == php_pkg::CMD_WORD && 32'(idx_r) < 32'(RW_DEPTH)) begin
      rw_mem[RWAW'(idx_r)] <= val_r;
    end
    if (ctl.rw_rd) begin
      rw_q <= rw_mem[RWAW'(rw_addr_full)];
    end
  end

  // bucket factors
  always_ff @(posedge clk) begin
    if (ctl.wr && cmd_r == php_pkg::CMD_FACTOR && 32'(idx_r) < 32'(MAX_BUCKETS)) begin
      fac_mem[FAW'(idx_r)] <= val_r;
    end
    if (ctl.fac_rd) begin
      fac_q <= fac_mem[FAW'(b)];
    end
  end

  // choice values, out of range reads as zero
  always_ff @(posedge clk) begin
    if (ctl.wr && cmd_r == php_pkg::CMD_CHOICE && 32'(idx_r) < 32'(RANGE_ENTRIES)) begin
      ch_mem[CAW'(idx_r)] <= val_r[1:0];
    end
    if (ctl.ch_rd) begin
      ch_q  <= ch_mem[CAW'(ch_f)];
      ch_ok <= 32'(ch_f) < 32'(RANGE_ENTRIES);
    end
  end

  // shared 32x32 multiplier, three passes for a wrapping 64-bit product
  logic [63:0] mul_a, mul_b, mp;
  logic [31:0] op_x, op_y;

  assign mul_a = ctl.mul_src ? a_reg : ((ctl.hsel == 2'd0) ? split_q : pair_q);
  assign mul_b = ctl.mul_src ? fac_q : (kw & kmask);

  always_comb begin
    case (ctl.mul_step)
      2'd0: begin
        op_x = mul_a[31:0];
        op_y = mul_b[31:0];
      end
      2'd1: begin
        op_x = mul_a[31:0];
        op_y = mul_b[63:32];
      end
      default: begin
        op_x = mul_a[63:32];
        op_y = mul_b[31:0];
      end
    endcase
  end
  assign mp = op_x * op_y;

  always_ff @(posedge clk) begin
    if (ctl.mul_en) begin
      if (ctl.mul_step == 2'd0) begin
        prod <= mp;
      end else begin
        prod <= {prod[63:32] + mp[31:0], prod[31:0]};
      end
    end
  end

  // universal hash accumulator and chunk shifter
  always_ff @(posedge clk) begin
    if (ctl.ci_load) begin
      ci <= n;
    end else if (ctl.ci_dec) begin
      ci <= ci - NW'(1);
    end
    if (ctl.r_init) begin
      r  <= ((ctl.hsel == 2'd0) ? split_q : pair_q) & hmask;
      kw <= key_r;
    end else if (ctl.acc) begin
      r  <= (r + (prod & hmask)) & hmask;
      kw <= kw >> k;
    end
  end

  // modulo unit operands
  logic [63:0] div_dvd, div_dsr, rem;
  logic        div_done;

  always_comb begin
    if (ctl.div_src) begin
      div_dvd = prod ^ x_reg;
      div_dsr = 64'(range - 13'(ctl.jsel));
    end else begin
      div_dvd = r >> k;
      div_dsr = (ctl.hsel == 2'd0) ? 64'(m_full) : 64'(rows_full);
    end
  end

  php_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.div_start),
    .dividend  (div_dvd),
    .divisor   (div_dsr),
    .done      (div_done),
    .remainder (rem)
  );

  // hash results, bucket range and candidate operands
  always_ff @(posedge clk) begin
    if (ctl.hres_store) begin
      case (ctl.hsel)
        2'd0:    b    <= BW'(rem);
        2'd1:    row0 <= RWW'(rem);
        default: row1 <= RWW'(rem);
      endcase
    end
    if (ctl.base_cap) begin
      base <= off_q;
    end
    if (ctl.top_cap) begin
      range <= off_q - base;
    end
    if (ctl.a_cap) begin
      a_reg <= rw_q;
    end
    if (ctl.x_cap) begin
      x_reg <= rw_q;
    end
  end

  // candidates: store residues, then make them distinct and add the base
  logic [13:0] f1n, f2n, f2i;

  always_comb begin
    f1n = (f[1] >= f[0]) ? f[1] + 14'd1 : f[1];
    f2i = f[2] + 14'd1;
    if (f[2] >= f[0]) begin
      f2n = (f2i >= f1n) ? f2i + 14'd1 : f2i;
    end else if (f[2] >= f1n) begin
      f2n = (f2i >= f[0]) ? f2i + 14'd1 : f2i;
    end else begin
      f2n = f[2];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.f_store) begin
      f[ctl.jsel] <= 14'(rem);
    end else if (ctl.fix) begin
      f[0] <= f[0] + 14'(base);
      f[1] <= f1n + 14'(base);
      f[2] <= f2n + 14'(base);
    end
  end

  // choice sum
  always_ff @(posedge clk) begin
    if (ctl.ch_acc) begin
      sum <= (ctl.ch_clr ? 4'd0 : sum) + (ch_ok ? 4'(ch_q) : 4'd0);
    end
  end

  // result register
  logic [1:0] pick;
  assign pick = php_pkg::mod3(sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= ctl.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.out_fire) begin
      empty_bucket <= ctl.out_empty;
      hash_value   <= ctl.out_empty ? 12'd0 : f[pick][11:0];
    end
  end

  // status
  assign st.ci_zero  = (ci == '0);
  assign st.div_done = div_done;
  assign st.empty    = {1'b0, off_q} < ({1'b0, base} + 14'd3);

endmodule

### rtl/core/php_ctrl.sv
// controller state machine sequencing writes and evaluations
// depends on php_pkg; drives the commands of php_datapath
module php_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [2:0]     command,
  input  php_pkg::stat_t st,
  output php_pkg::ctrl_t ctl,
  output logic           busy
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_WRITE   = 5'd1;
  localparam logic [4:0] S_H_START = 5'd2;
  localparam logic [4:0] S_H_RD0   = 5'd3;
  localparam logic [4:0] S_H_FIRST = 5'd4;
  localparam logic [4:0] S_H_RD    = 5'd5;
  localparam logic [4:0] S_H_MUL   = 5'd6;
  localparam logic [4:0] S_H_ACC   = 5'd7;
  localparam logic [4:0] S_H_DIV   = 5'd8;
  localparam logic [4:0] S_H_DWAIT = 5'd9;
  localparam logic [4:0] S_OFF_B   = 5'd10;
  localparam logic [4:0] S_OFF_T   = 5'd11;
  localparam logic [4:0] S_OFF_CHK = 5'd12;
  localparam logic [4:0] S_FAC     = 5'd13;
  localparam logic [4:0] S_W_RDA   = 5'd14;
  localparam logic [4:0] S_W_RDX   = 5'd15;
  localparam logic [4:0] S_W_MUL   = 5'd16;
  localparam logic [4:0] S_W_DIV   = 5'd17;
  localparam logic [4:0] S_W_DWAIT = 5'd18;
  localparam logic [4:0] S_FIX     = 5'd19;
  localparam logic [4:0] S_CH0     = 5'd20;
  localparam logic [4:0] S_CH1     = 5'd21;
  localparam logic [4:0] S_CH2     = 5'd22;
  localparam logic [4:0] S_CH3     = 5'd23;
  localparam logic [4:0] S_OUT     = 5'd24;
  localparam logic [4:0] S_OUT_E   = 5'd25;

  logic [4:0] state, state_next;
  logic [1:0] hsel, hsel_next;
  logic [1:0] cnt, cnt_next;
  logic [1:0] j, j_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      hsel  <= 2'd0;
      cnt   <= 2'd0;
      j     <= 2'd0;
    end else begin
      state <= state_next;
      hsel  <= hsel_next;
      cnt   <= cnt_next;
      j     <= j_next;
    end
  end

  assign busy = (state != S_IDLE);

  // next state and command decode
  always_comb begin
    state_next   = state;
    hsel_next    = hsel;
    cnt_next     = cnt;
    j_next       = j;
    ctl          = '0;
    ctl.hsel     = hsel;
    ctl.jsel     = j;
    ctl.mul_step = cnt;
    case (state)
      S_IDLE: begin
        ctl.load = start;
        if (start) begin
          hsel_next  = 2'd0;
          state_next = (command == php_pkg::CMD_EVAL) ? S_H_START : S_WRITE;
        end
      end
      S_WRITE: begin
        ctl.wr     = 1'b1;
        state_next = S_IDLE;
      end
      // universal hash over the key chunks
      S_H_START: begin
        ctl.ci_load = 1'b1;
        state_next  = S_H_RD0;
      end
      S_H_RD0: begin
        ctl.coef_rd = 1'b1;
        state_next  = S_H_FIRST;
      end
      S_H_FIRST: begin
        ctl.r_init = 1'b1;
        if (st.ci_zero) begin
          state_next = S_H_DIV;
        end else begin
          ctl.ci_dec = 1'b1;
          state_next = S_H_RD;
        end
      end
      S_H_RD: begin
        ctl.coef_rd = 1'b1;
        cnt_next    = 2'd0;
        state_next  = S_H_MUL;
      end
      S_H_MUL: begin
        ctl.mul_en = 1'b1;
        cnt_next   = cnt + 2'd1;
        if (cnt == 2'd2) begin
          state_next = S_H_ACC;
        end
      end
      S_H_ACC: begin
        ctl.acc = 1'b1;
        if (st.ci_zero) begin
          state_next = S_H_DIV;
        end else begin
          ctl.ci_dec = 1'b1;
          state_next = S_H_RD;
        end
      end
      S_H_DIV: begin
        ctl.div_start = 1'b1;
        state_next    = S_H_DWAIT;
      end
      S_H_DWAIT: begin
        if (st.div_done) begin
          ctl.hres_store = 1'b1;
          case (hsel)
            2'd0:    state_next = S_OFF_B;
            2'd1: begin
              hsel_next  = 2'd2;
              state_next = S_H_START;
            end
            default: state_next = S_FAC;
          endcase
        end
      end
      // bucket range
      S_OFF_B: begin
        ctl.off_rd = 1'b1;
        state_next = S_OFF_T;
      end
      S_OFF_T: begin
        ctl.off_rd   = 1'b1;
        ctl.off_sel  = 1'b1;
        ctl.base_cap = 1'b1;
        state_next   = S_OFF_CHK;
      end
      S_OFF_CHK: begin
        ctl.top_cap = 1'b1;
        if (st.empty) begin
          state_next = S_OUT_E;
        end else begin
          hsel_next  = 2'd1;
          state_next = S_H_START;
        end
      end
      // three candidates from the random table
      S_FAC: begin
        ctl.fac_rd = 1'b1;
        j_next     = 2'd0;
        state_next = S_W_RDA;
      end
      S_W_RDA: begin
        ctl.rw_rd  = 1'b1;
        state_next = S_W_RDX;
      end
      S_W_RDX: begin
        ctl.rw_rd  = 1'b1;
        ctl.rw_sel = 1'b1;
        ctl.a_cap  = 1'b1;
        cnt_next   = 2'd0;
        state_next = S_W_MUL;
      end
      S_W_MUL: begin
        ctl.mul_en  = 1'b1;
        ctl.mul_src = 1'b1;
        ctl.x_cap   = (cnt == 2'd0);
        cnt_next    = cnt + 2'd1;
        if (cnt == 2'd2) begin
          state_next = S_W_DIV;
        end
      end
      S_W_DIV: begin
        ctl.div_start = 1'b1;
        ctl.div_src   = 1'b1;
        state_next    = S_W_DWAIT;
      end
      S_W_DWAIT: begin
        ctl.div_src = 1'b1;
        if (st.div_done) begin
          ctl.f_store = 1'b1;
          j_next      = j + 2'd1;
          state_next  = (j == 2'd2) ? S_FIX : S_W_RDA;
        end
      end
      S_FIX: begin
        ctl.fix    = 1'b1;
        state_next = S_CH0;
      end
      // choice lookups and sum
      S_CH0: begin
        ctl.ch_rd  = 1'b1;
        ctl.ch_sel = 2'd0;
        state_next = S_CH1;
      end
      S_CH1: begin
        ctl.ch_rd  = 1'b1;
        ctl.ch_sel = 2'd1;
        ctl.ch_acc = 1'b1;
        ctl.ch_clr = 1'b1;
        state_next = S_CH2;
      end
      S_CH2: begin
        ctl.ch_rd  = 1'b1;
        ctl.ch_sel = 2'd2;
        ctl.ch_acc = 1'b1;
        state_next = S_CH3;
      end
      S_CH3: begin
        ctl.ch_acc = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        ctl.out_fire = 1'b1;
        state_next   = S_IDLE;
      end
      S_OUT_E: begin
        ctl.out_fire  = 1'b1;
        ctl.out_empty = 1'b1;
        state_next    = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/perfect_hash_lookup_top.sv
// top level of the perfect hash lookup: register port, controller and datapath
// depends on php_pkg, php_ctrl and php_datapath
//
// A command is taken when start is high and busy is low; busy stays high until the
// command is finished. A table write keeps busy high for 1 cycle. The length of an
// evaluation grows with the clamped chunk count n and is set by the bit-serial modulo
// unit (six uses) and the shared 32x32 multiplier, which makes three passes per 64-bit
// product. In the cycle after an evaluation ends, valid is high for exactly one cycle
// with hash_value and empty_bucket; the receiver has to take it in that cycle. Tables
// hold no reset value and must be loaded before they are used.
module perfect_hash_lookup_top #(
  parameter int MAX_CHUNKS     = php_pkg::MAX_CHUNKS_DEF,
  parameter int MAX_BUCKETS    = php_pkg::MAX_BUCKETS_DEF,
  parameter int MAX_TABLE_ROWS = php_pkg::MAX_TABLE_ROWS_DEF,
  parameter int RANGE_ENTRIES  = php_pkg::RANGE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  command,
  input  logic [63:0] key,
  input  logic [12:0] table_index,
  input  logic [63:0] table_value,
  output logic        valid,
  output logic [11:0] hash_value,
  output logic        empty_bucket
);

  php_pkg::cfg_t  cfg;
  php_pkg::ctrl_t ctl;
  php_pkg::stat_t st;
  logic [2:0]     reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];

  // configuration register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_bits      <= php_pkg::CHUNK_BITS_RST;
      cfg.chunk_count     <= php_pkg::CHUNK_COUNT_RST;
      cfg.bucket_count    <= php_pkg::BUCKETS_RST;
      cfg.split_mask_bits <= php_pkg::SPLIT_MASK_RST;
      cfg.pair_mask_bits  <= php_pkg::PAIR_MASK_RST;
      cfg.table_rows      <= php_pkg::TABLE_ROWS_RST;
    end else if (psel && penable && pwrite) begin
      case (reg_idx)
        php_pkg::REG_CHUNK_BITS:  cfg.chunk_bits      <= pwdata[5:0];
        php_pkg::REG_CHUNK_COUNT: cfg.chunk_count     <= pwdata[3:0];
        php_pkg::REG_BUCKETS:     cfg.bucket_count    <= pwdata[8:0];
        php_pkg::REG_SPLIT_MASK:  cfg.split_mask_bits <= pwdata[6:0];
        php_pkg::REG_PAIR_MASK:   cfg.pair_mask_bits  <= pwdata[6:0];
        php_pkg::REG_TABLE_ROWS:  cfg.table_rows      <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  // register read back
  always_comb begin
    case (reg_idx)
      php_pkg::REG_CHUNK_BITS:  prdata = 32'(cfg.chunk_bits);
      php_pkg::REG_CHUNK_COUNT: prdata = 32'(cfg.chunk_count);
      php_pkg::REG_BUCKETS:     prdata = 32'(cfg.bucket_count);
      php_pkg::REG_SPLIT_MASK:  prdata = 32'(cfg.split_mask_bits);
      php_pkg::REG_PAIR_MASK:   prdata = 32'(cfg.pair_mask_bits);
      php_pkg::REG_TABLE_ROWS:  prdata = 32'(cfg.table_rows);
      default:                  prdata = 32'd0;
    endcase
  end

  php_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .st      (st),
    .ctl     (ctl),
    .busy    (busy)
  );

  php_datapath #(
    .MAX_CHUNKS     (MAX_CHUNKS),
    .MAX_BUCKETS    (MAX_BUCKETS),
    .MAX_TABLE_ROWS (MAX_TABLE_ROWS),
    .RANGE_ENTRIES  (RANGE_ENTRIES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .command      (command),
    .key          (key),
    .table_index  (table_index),
    .table_value  (table_value),
    .ctl          (ctl),
    .st           (st),
    .valid        (valid),
    .hash_value   (hash_value),
    .empty_bucket (empty_bucket)
  );

  // a result only follows a command that was in progress
  assert property (@(posedge clk) disable iff (rst) valid |-> $past(busy))
    else $error("result without a command in progress");

  // one result per evaluation
  assert property (@(posedge clk) disable iff (rst) valid |=> !valid)
    else $error("result strobe longer than one cycle");

  // an accepted command always occupies the block
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted command did not raise busy");

  // an empty bucket gives a zero hash
  assert property (@(posedge clk) disable iff (rst)
    (valid && empty_bucket) |-> (hash_value == 12'd0))
    else $error("empty bucket with nonzero hash");

endmodule
